/* sv/scec_pkg.sv */
// shared types and constants for the segment cell edge crossing block
package scec_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIFF_W    = 33;
    localparam int QUO_W     = FRAC_BITS;
    localparam int NUM_CELLS = FRAC_BITS;

    typedef enum logic [1:0]
    {
        SIDE_LEFT   = 2'd0,
        SIDE_RIGHT  = 2'd1,
        SIDE_BOTTOM = 2'd2,
        SIDE_TOP    = 2'd3
    } side_t;

    typedef struct packed
    {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] cell_min_x;
        logic signed [31:0] cell_min_y;
        logic signed [31:0] cell_max_x;
        logic signed [31:0] cell_max_y;
        logic signed [31:0] start_curvature;
        logic signed [31:0] end_curvature;
        logic        [15:0] source_tag;
    } seg_in_t;

    typedef struct packed
    {
        logic        [1:0]  edge_side;
        logic signed [31:0] cross_x;
        logic signed [31:0] cross_y;
        logic        [16:0] fraction;
        logic signed [31:0] cross_curvature;
        logic        [15:0] owner_tag;
        logic               last;
    } cross_out_t;

    // one crossing job travelling down the divider chain
    typedef struct packed
    {
        logic                     valid;
        logic [1:0]               side;
        logic                     is_last;
        logic                     sat;
        logic [FRAC_BITS:0]       sat_val;
        logic [DIFF_W-1:0]        den;
        logic [DIFF_W:0]          rem;
        logic [QUO_W-1:0]         quo;
        logic signed [31:0]       grid;
        logic signed [31:0]       s_other;
        logic signed [31:0]       e_other;
        logic signed [31:0]       cs;
        logic signed [31:0]       ce;
        logic [15:0]              tag;
    } job_t;

endpackage

/* sv/segment_cell_edge_crossing.sv */
// top level of the segment cell edge crossing block
//
// in channel: one segment per transfer (in_valid, in_stall, in_data)
// out channel: one crossing per transfer (out_valid, out_stall, out_data)
// a segment whose end lies in the cell gives no crossing; otherwise one
// crossing per crossed edge, left, right, bottom, top order, last set on
// the final one
// alpha comes from a chain of FRAC_BITS restoring divider cells, one
// quotient bit per cell; two interpolation stages follow, the second
// being the output register that drives out_valid and out_data
// a segment with two crossings feeds its two jobs into the chain entry
// one after the other, holding in_stall in between; without out_stall,
// one segment per cycle is taken when each has at most one crossing
// out_stall while out_valid is set freezes the whole chain; in_stall follows it
// reset empties the chain; no results are pending afterwards
module segment_cell_edge_crossing
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  scec_pkg::seg_in_t     in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output scec_pkg::cross_out_t  out_data
);
    import scec_pkg::*;

    logic     hold;
    logic     pend_reg;
    logic     pend_next;
    job_t     pjob_reg;
    job_t     jx;
    job_t     jy;
    job_t     entry;
    logic     x_hit;
    logic     y_hit;
    logic     take;
    job_t     chain [NUM_CELLS+1];
    logic     lerp_valid;
    cross_out_t lerp_item;

    // build a job from start, end and grid line along one axis
    function automatic job_t make_job(
        input logic [1:0]         side,
        input logic signed [31:0] s,
        input logic signed [31:0] e,
        input logic signed [31:0] g
    );
        job_t                 j;
        logic signed [32:0]   num;
        logic signed [32:0]   den;
        logic [32:0]          an;
        logic [32:0]          ad;
        j         = '0;
        num       = 33'(g) - 33'(s);
        den       = 33'(e) - 33'(s);
        an        = num[32] ? 33'(-num) : 33'(num);
        ad        = den[32] ? 33'(-den) : 33'(den);
        j.valid   = 1'b1;
        j.side    = side;
        j.grid    = g;
        j.den     = ad;
        j.rem     = {1'b0, an};
        j.quo     = '0;
        j.sat     = 1'b1;
        if (num == '0)
            j.sat_val = '0;
        else if (den == '0)
            j.sat_val = (FRAC_BITS+1)'(1) << FRAC_BITS;
        else if (num[32] != den[32])
            j.sat_val = '0;
        else if (an >= ad)
            j.sat_val = (FRAC_BITS+1)'(1) << FRAC_BITS;
        else
            j.sat = 1'b0;
        return j;
    endfunction

    assign hold = out_valid && out_stall;

    always_comb
    begin
        x_hit = (in_data.end_x < in_data.cell_min_x) || (in_data.end_x >= in_data.cell_max_x);
        y_hit = (in_data.end_y < in_data.cell_min_y) || (in_data.end_y >= in_data.cell_max_y);
        jx = make_job((in_data.end_x < in_data.cell_min_x) ? SIDE_LEFT : SIDE_RIGHT,
                      in_data.start_x, in_data.end_x,
                      (in_data.end_x < in_data.cell_min_x) ? in_data.cell_min_x
                                                           : in_data.cell_max_x);
        jx.s_other = in_data.start_y;
        jx.e_other = in_data.end_y;
        jx.cs      = in_data.start_curvature;
        jx.ce      = in_data.end_curvature;
        jx.tag     = in_data.source_tag;
        jx.is_last = !y_hit;
        jy = make_job((in_data.end_y < in_data.cell_min_y) ? SIDE_BOTTOM : SIDE_TOP,
                      in_data.start_y, in_data.end_y,
                      (in_data.end_y < in_data.cell_min_y) ? in_data.cell_min_y
                                                           : in_data.cell_max_y);
        jy.s_other = in_data.start_x;
        jy.e_other = in_data.end_x;
        jy.cs      = in_data.start_curvature;
        jy.ce      = in_data.end_curvature;
        jy.tag     = in_data.source_tag;
        jy.is_last = 1'b1;
    end

    assign in_stall = hold || pend_reg;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        pend_next = pend_reg;
        entry     = '0;
        if (pend_reg)
        begin
            entry     = pjob_reg;
            pend_next = 1'b0;
        end
        else if (take)
        begin
            if (x_hit)
            begin
                entry     = jx;
                pend_next = y_hit;
            end
            else if (y_hit)
            begin
                entry = jy;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else if (!hold)
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pjob_reg <= jy;
        end
    end

    assign chain[0] = entry;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        scec_div_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .hold    (hold),
            .job_in  (chain[i]),
            .job_out (chain[i+1])
        );
    end

    scec_lerp u_lerp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .hold      (hold),
        .job_in    (chain[NUM_CELLS]),
        .out_valid (lerp_valid),
        .out_item  (lerp_item)
    );

    assign out_valid = lerp_valid;
    assign out_data  = lerp_item;

    a_pend_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> in_stall)
        else $error("input taken while second crossing pending");

    a_pend_from_two: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pend_reg) |-> $past(take && x_hit && y_hit))
        else $error("pending crossing without a two crossing segment");

    a_fraction_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.fraction <= 17'((FRAC_BITS+1)'(1) << FRAC_BITS))
        else $error("fraction above one");

    a_hold_output: assert property (@(posedge clk) disable iff (!rst_n)
        $past(hold) |-> $stable(out_data))
        else $error("stalled output changed");

endmodule

/* sv/scec_div_cell.sv */
// one restoring division step of the alpha divider chain
module scec_div_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          hold,
    input  scec_pkg::job_t job_in,
    output scec_pkg::job_t job_out
);
    import scec_pkg::*;

    logic               valid_reg;
    job_t               job_reg;
    job_t               job_next;
    logic [DIFF_W+1:0]  trial;
    logic [DIFF_W:0]    shifted;

    always_comb
    begin
        job_next = job_in;
        shifted  = {job_in.rem[DIFF_W-1:0], 1'b0};
        trial    = {1'b0, shifted} - {2'b00, job_in.den};
        if (!trial[DIFF_W+1])
        begin
            job_next.rem = trial[DIFF_W:0];
            job_next.quo = {job_in.quo[QUO_W-2:0], 1'b1};
        end
        else
        begin
            job_next.rem = shifted;
            job_next.quo = {job_in.quo[QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            valid_reg <= job_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold)
        begin
            job_reg <= job_next;
        end
    end

    always_comb
    begin
        job_out       = job_reg;
        job_out.valid = valid_reg;
    end

endmodule

/* sv/scec_lerp.sv */
// interpolation stages and output register for one finished crossing
module scec_lerp
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  hold,
    input  scec_pkg::job_t        job_in,
    output logic                  out_valid,
    output scec_pkg::cross_out_t  out_item
);
    import scec_pkg::*;

    logic [FRAC_BITS:0]   alpha;
    logic signed [32:0]   d_pos;
    logic signed [32:0]   d_crv;
    logic signed [50:0]   p_pos;
    logic signed [50:0]   p_crv;

    logic                 v1_reg;
    logic [1:0]           side1_reg;
    logic                 last1_reg;
    logic [FRAC_BITS:0]   alpha1_reg;
    logic signed [31:0]   grid1_reg;
    logic signed [31:0]   so1_reg;
    logic signed [31:0]   cs1_reg;
    logic [15:0]          tag1_reg;
    logic signed [50:0]   ppos1_reg;
    logic signed [50:0]   pcrv1_reg;

    logic                 v2_reg;
    cross_out_t           out_reg;
    cross_out_t           out_next;
    logic signed [32:0]   other_sum;
    logic signed [32:0]   crv_sum;

    assign alpha = job_in.sat ? job_in.sat_val : {1'b0, job_in.quo};
    assign d_pos = 33'(job_in.e_other) - 33'(job_in.s_other);
    assign d_crv = 33'(job_in.ce) - 33'(job_in.cs);
    assign p_pos = 51'(d_pos) * $signed({1'b0, alpha});
    assign p_crv = 51'(d_crv) * $signed({1'b0, alpha});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (!hold)
        begin
            v1_reg <= job_in.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold)
        begin
            side1_reg  <= job_in.side;
            last1_reg  <= job_in.is_last;
            alpha1_reg <= alpha;
            grid1_reg  <= job_in.grid;
            so1_reg    <= job_in.s_other;
            cs1_reg    <= job_in.cs;
            tag1_reg   <= job_in.tag;
            ppos1_reg  <= p_pos;
            pcrv1_reg  <= p_crv;
            out_reg    <= out_next;
        end
    end

    // arithmetic shift of a signed product is floor division by 2^FRAC_BITS
    assign other_sum = 33'(so1_reg) + 33'(ppos1_reg >>> FRAC_BITS);
    assign crv_sum   = 33'(cs1_reg) + 33'(pcrv1_reg >>> FRAC_BITS);

    always_comb
    begin
        out_next.edge_side       = side1_reg;
        out_next.fraction        = 17'(alpha1_reg);
        out_next.cross_curvature = crv_sum[31:0];
        out_next.owner_tag       = tag1_reg;
        out_next.last            = last1_reg;
        if (side1_reg == SIDE_LEFT || side1_reg == SIDE_RIGHT)
        begin
            out_next.cross_x = grid1_reg;
            out_next.cross_y = other_sum[31:0];
        end
        else
        begin
            out_next.cross_x = other_sum[31:0];
            out_next.cross_y = grid1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = out_reg;

endmodule
